@@ sv/l1_squared_hinge_loss_gradient_macros.svh @@
// assertion macros for the l1 squared hinge loss gradient block
`ifndef L1_SQUARED_HINGE_LOSS_GRADIENT_MACROS_SVH
`define L1_SQUARED_HINGE_LOSS_GRADIENT_MACROS_SVH
`ifndef SYNTHESIS
`define L1H_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define L1H_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: never");
`else
`define L1H_ASSERT_IMPL(label, clk, rst, prop)
`define L1H_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ sv/l1h_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1h_pkg
// types and constants shared by the loss gradient block
// ----------------------------------------------------------------------------
package l1h_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic CFG_LAMBDA = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = -48'sh8000_0000_0000;
  localparam logic [47:0] LOSS_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [41:0] ONE_Q24 = 42'sd16777216;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_DOT_RD, S_DOT_ACC, S_DOT_END,
    S_UPD_RD, S_UPD_MUL, S_UPD_WR, S_L1_RD, S_L1_ACC, S_L1_MUL, S_L1_ADD,
    S_EMIT_RD, S_EMIT_CALC, S_EMIT_OUT
  } state_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(ACC_MAX)) return ACC_MAX;
    if (v < 50'(ACC_MIN)) return ACC_MIN;
    return v[47:0];
  endfunction

endpackage

@@ sv/l1_squared_hinge_loss_gradient.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1_squared_hinge_loss_gradient
// l1-regularized squared hinge loss and pseudo-gradient over memory state
// ----------------------------------------------------------------------------
// operation: a weight load or a plain feature element is taken directly in idle
// a last element starts the margin pass, then a pass over all MAX_FEATURES entries
// to update gradients and clear the buffer
// a finish computes |w|1, emits one result per element, and starts a
// clearing pass over MAX_FEATURES entries when n < MAX_FEATURES
// reset: a clearing pass over MAX_FEATURES entries; lambda resets to 0, feature_count to 32
module l1_squared_hinge_loss_gradient #(
  parameter int MAX_FEATURES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: op[1:0], index[7:2], value[23:8]
  input  logic [23:0] s_tdata,
  // tuser: label_negative
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: grad_index[5:0], gradient[37:6], loss[69:38], zero fill
  output logic [71:0] m_tdata,
  output logic        m_tlast
);
  import l1h_pkg::*;
  `include "l1_squared_hinge_loss_gradient_macros.svh"

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int MEM_DEPTH = 1 << AW;

  // configuration registers
  logic [15:0] lambda;
  logic [6:0]  feature_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda <= '0;
      feature_count <= 7'd32;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LAMBDA) lambda <= cfg_data;
      else feature_count <= cfg_data[6:0];
    end
  end

  // count in use, clamped to 1..MAX_FEATURES
  logic [6:0] n_use;
  always_comb begin
    if (feature_count == 7'd0) n_use = 7'd1;
    else if (feature_count > 7'(MAX_FEATURES)) n_use = 7'(MAX_FEATURES);
    else n_use = feature_count;
  end

  // request fields
  logic [1:0] in_op;
  logic [5:0] in_idx;
  logic signed [15:0] in_val;
  assign in_op  = s_tdata[1:0];
  assign in_idx = s_tdata[7:2];
  assign in_val = s_tdata[23:8];

  state_t state, state_next;
  logic [6:0] ptr;
  logic neg;
  logic clr_weights;
  logic signed [39:0] margin;
  logic [47:0] loss_acc;
  logic [31:0] d16;
  logic [21:0] l1_sum;
  logic signed [15:0] w_q, x_q;
  logic signed [47:0] g_q;
  logic [47:0] term_mag;
  logic [37:0] l1_prod;
  logic signed [31:0] grad_out;
  logic [31:0] loss_out;
  logic out_last;
  logic [AW-1:0] out_idx;

  // memory ports
  logic w_we, x_we, g_we;
  logic [AW-1:0] w_wa, x_wa, g_wa, rd_a;
  logic [15:0] w_wd, x_wd, w_rd, x_rd;
  logic [47:0] g_wd, g_rd;

  l1h_mem #(.DEPTH(MEM_DEPTH), .WIDTH(16)) u_w (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(rd_a), .rdata(w_rd));
  l1h_mem #(.DEPTH(MEM_DEPTH), .WIDTH(16)) u_x (
    .clk, .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(rd_a), .rdata(x_rd));
  l1h_mem #(.DEPTH(MEM_DEPTH), .WIDTH(48)) u_g (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(rd_a), .rdata(g_rd));

  assign rd_a = ptr[AW-1:0];
  assign s_tready = (state == S_IDLE);
  wire acc_in = s_tvalid && s_tready;

  // margin in q.24, d = 1 - y*m
  logic signed [41:0] d_full;
  always_comb begin
    d_full = neg ? ONE_Q24 + 42'(margin) : ONE_Q24 - 42'(margin);
  end

  // finish: pseudo-gradient of one element
  logic signed [49:0] lam16, g_adj;
  always_comb begin
    lam16 = 50'(signed'({1'b0, lambda, 4'd0}));
    if (w_q > 0) g_adj = 50'(sat48(50'(g_q) + lam16));
    else if (w_q < 0) g_adj = 50'(sat48(50'(g_q) - lam16));
    else if (50'(g_q) > lam16) g_adj = 50'(g_q) - lam16;
    else if (50'(g_q) < -lam16) g_adj = 50'(g_q) + lam16;
    else g_adj = 50'(g_q);
  end

  // gradient term
  logic signed [49:0] g_upd;
  always_comb begin
    g_upd = (neg == x_q[15]) ? 50'(g_q) - 50'(term_mag) : 50'(g_q) + 50'(term_mag);
  end

  // loss add with saturation
  function automatic logic [47:0] loss_add(input logic [47:0] a, input logic [47:0] t);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, t};
    return s[48] ? LOSS_MAX : s[47:0];
  endfunction

  function automatic logic [15:0] ax_r(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  always_comb begin
    state_next = state;
    w_we = 1'b0; w_wa = in_idx[AW-1:0]; w_wd = in_val;
    x_we = 1'b0; x_wa = in_idx[AW-1:0]; x_wd = in_val;
    g_we = 1'b0; g_wa = ptr[AW-1:0]; g_wd = sat48(g_upd);
    unique case (state)
      S_CLR: begin
        // weights are only cleared by the pass after reset
        w_we = clr_weights; x_we = 1'b1; g_we = 1'b1;
        w_wa = ptr[AW-1:0]; x_wa = ptr[AW-1:0];
        w_wd = '0; x_wd = '0; g_wd = '0;
        if (ptr == 7'(MAX_FEATURES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc_in) begin
          unique case (in_op)
            OP_LOAD: w_we = (7'(in_idx) < 7'(MAX_FEATURES));
            OP_SAMPLE: begin
              x_we = (7'(in_idx) < n_use);
              if (s_tlast) state_next = S_DOT_RD;
            end
            OP_FINISH: state_next = S_L1_RD;
            default: ;
          endcase
        end
      end
      S_DOT_RD: state_next = S_DOT_ACC;
      S_DOT_ACC: state_next = (ptr == n_use) ? S_DOT_END : S_DOT_ACC;
      S_DOT_END: state_next = d_full[41] ? S_UPD_WR : S_UPD_RD;
      S_UPD_RD: state_next = S_UPD_MUL;
      S_UPD_MUL: state_next = S_UPD_WR;
      S_UPD_WR: begin
        if (!d_full[41] && x_q != 0 && ptr < n_use) g_we = 1'b1;
        x_we = 1'b1; x_wa = g_wa; x_wd = '0;
        if (ptr == 7'(MAX_FEATURES - 1)) state_next = S_IDLE;
        else state_next = d_full[41] ? S_UPD_WR : S_UPD_RD;
      end
      S_L1_RD: state_next = S_L1_ACC;
      S_L1_ACC: state_next = (ptr == n_use) ? S_L1_MUL : S_L1_ACC;
      S_L1_MUL: state_next = S_L1_ADD;
      S_L1_ADD: state_next = S_EMIT_RD;
      S_EMIT_RD: state_next = S_EMIT_CALC;
      S_EMIT_CALC: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (m_tready) begin
          g_we = 1'b1; g_wa = out_idx; g_wd = '0;
          x_we = 1'b1; x_wa = out_idx; x_wd = '0;
          if (out_last) state_next = (n_use < 7'(MAX_FEATURES)) ? S_CLR : S_IDLE;
          else state_next = S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ptr <= '0;
      loss_acc <= '0;
      neg <= 1'b0;
      clr_weights <= 1'b1;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLR: begin
          ptr <= (ptr == 7'(MAX_FEATURES - 1)) ? 7'd0 : ptr + 7'd1;
          if (ptr == 7'(MAX_FEATURES - 1)) clr_weights <= 1'b0;
        end
        S_IDLE: begin
          ptr <= '0;
          if (acc_in) neg <= s_tuser;
          margin <= '0;
          l1_sum <= '0;
        end
        S_DOT_RD: ptr <= ptr + 7'd1;
        S_DOT_ACC: begin
          margin <= margin + 40'(signed'(w_rd) * signed'(x_rd));
          if (ptr != n_use) ptr <= ptr + 7'd1;
        end
        S_DOT_END: begin
          ptr <= '0;
          if (!d_full[41]) begin
            d16 <= d_full[39:8];
            loss_acc <= loss_add(loss_acc, 48'((64'(d_full[39:8]) * 64'(d_full[39:8])) >> 16));
          end
        end
        S_UPD_RD: ;
        S_UPD_MUL: begin
          x_q <= x_rd; g_q <= g_rd;
          term_mag <= 48'((64'(d16) * 64'(ax_r(x_rd)) * 64'd2) >> 12);
        end
        S_UPD_WR: ptr <= ptr + 7'd1;
        S_L1_RD: ptr <= ptr + 7'd1;
        S_L1_ACC: begin
          l1_sum <= l1_sum + 22'(ax_r(w_rd));
          if (ptr != n_use) ptr <= ptr + 7'd1;
        end
        S_L1_MUL: l1_prod <= 38'(lambda) * 38'(l1_sum);
        S_L1_ADD: begin
          loss_acc <= loss_add(loss_acc, 48'(l1_prod >> 8));
          ptr <= '0;
        end
        S_EMIT_RD: ;
        S_EMIT_CALC: begin
          w_q <= w_rd; g_q <= g_rd;
        end
        S_EMIT_OUT: begin
          if (m_tready) begin
            ptr <= out_last ? 7'd0 : ptr + 7'd1;
            if (out_last) loss_acc <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output fields formed combinationally, valid in S_EMIT_OUT
  always_comb begin
    out_idx = ptr[AW-1:0];
    out_last = (ptr == n_use - 7'd1);
    loss_out = (loss_acc > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : loss_acc[31:0];
    if (g_adj > 50'sd2147483647) grad_out = 32'sh7FFF_FFFF;
    else if (g_adj < -50'sd2147483648) grad_out = 32'sh8000_0000;
    else grad_out = g_adj[31:0];
  end

  assign m_tvalid = (state == S_EMIT_OUT);
  assign m_tlast = out_last;
  assign m_tdata = {2'b00, loss_out, grad_out, 6'(ptr)};

  `L1H_ASSERT_NEVER(a_busy_ready, clk, rst, s_tready && m_tvalid)
  `L1H_ASSERT_IMPL(a_emit_idx, clk, rst, m_tvalid |-> ptr < n_use)
  `L1H_ASSERT_IMPL(a_done, clk, rst, (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
  `L1H_ASSERT_NEVER(a_ptr_range, clk, rst, ptr > 7'(MAX_FEATURES) + 7'd1)
endmodule

@@ sv/l1h_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1h_mem
// simple dual port synchronous memory, registered read data
// ----------------------------------------------------------------------------
module l1h_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
